>>> sv/vtg_pkg.sv
`default_nettype none

package vtg_pkg;

    localparam int FIELD_BITS = 12;
    localparam int CNT_BITS   = 14;
    // wide enough for a sum of four fields, a counter plus one, and no overflow
    localparam int CMP_BITS   = ((FIELD_BITS + 2 > CNT_BITS) ? FIELD_BITS + 2 : CNT_BITS) + 1;

    localparam int IN_BITS    = 2;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 2 * CNT_BITS + 5;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int REG_IDX_BITS = 3;

    typedef logic [FIELD_BITS-1:0] field_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [CMP_BITS-1:0]   cmp_t;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_H_VISIBLE     = 3'd0,
        REG_H_FRONT_PORCH = 3'd1,
        REG_H_SYNC_LEN    = 3'd2,
        REG_H_BACK_PORCH  = 3'd3,
        REG_V_VISIBLE     = 3'd4,
        REG_V_FRONT_PORCH = 3'd5,
        REG_V_SYNC_LEN    = 3'd6,
        REG_V_BACK_PORCH  = 3'd7
    } reg_idx_t;

    // raster boundaries derived from the register set
    typedef struct packed {
        logic valid;
        cmp_t h_visible;
        cmp_t h_sync_start;
        cmp_t h_sync_end;
        cmp_t h_total;
        cmp_t v_visible;
        cmp_t v_sync_start;
        cmp_t v_sync_end;
        cmp_t v_total;
    } timing_t;

    typedef struct packed {
        logic v_sync;
        logic h_sync;
        logic v_blank;
        logic h_blank;
        logic active_video;
        cnt_t pixel_index;
        cnt_t line_index;
    } result_t;

endpackage

`default_nettype wire

>>> sv/video_timing_generator_unit.sv
// Raster timing generator, one input word per pixel-clock tick.
// Slave channel (s_t*): each word carries restart and output_enable. Restart
// clears the pixel and line counters before the tick is reported.
// Master channel (m_t*): one word per input word with the current line and
// pixel, active video, horizontal/vertical blank and sync flags. All fields
// read zero when output_enable is low or either visible size is zero.
// Configuration: eight 12-bit registers written through cfg_wr_en/cfg_index/
// cfg_data. Write only while no word is in flight (not enforced by the block).
// The counters and flags are evaluated from the counter registers and the
// register set in the accept cycle and land in the output register.
// Throughput is one word per cycle while m_tready stays high, set by the
// single output register; the next word is taken in the same cycle the held
// word leaves. When the receiver stalls, the output word holds and s_tready
// drops; counters only move on accepted words.
// Reset (aresetn low, synchronous) clears counters, cfg registers and m_tvalid.
`default_nettype none

module video_timing_generator_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    // [0] restart, [1] output_enable
    input  wire logic [vtg_pkg::IN_TDATA_W-1:0]      s_tdata,
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    // [13:0] line_index, [27:14] pixel_index, [28] active_video,
    // [29] h_blank, [30] v_blank, [31] h_sync, [32] v_sync
    output      logic [vtg_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  wire logic                                cfg_wr_en,
    input  wire logic [vtg_pkg::REG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [vtg_pkg::FIELD_BITS-1:0]      cfg_data
);

    localparam vtg_pkg::cnt_t CNT_MAX = '1;

    vtg_pkg::timing_t timing;
    vtg_pkg::cnt_t    pixel_cnt_reg, pixel_cnt_next;
    vtg_pkg::cnt_t    line_cnt_reg, line_cnt_next;
    vtg_pkg::result_t res_reg, res_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             s_accept;
    logic             restart, output_enable;
    vtg_pkg::cnt_t    px, ln;
    vtg_pkg::cmp_t    px_w, ln_w;
    logic             vb, hb, vs, hs, px_wrap, ln_wrap;

    vtg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    assign restart       = s_tdata[0];
    assign output_enable = s_tdata[1];
    assign s_tready      = !m_tvalid_reg || m_tready;
    assign s_accept      = s_tvalid && s_tready;

    always_comb begin
        px   = restart ? '0 : pixel_cnt_reg;
        ln   = restart ? '0 : line_cnt_reg;
        px_w = vtg_pkg::cmp_t'(px);
        ln_w = vtg_pkg::cmp_t'(ln);

        vb = ln_w >= timing.v_visible;
        hb = !vb && (px_w >= timing.h_visible);
        vs = (ln_w >= timing.v_sync_start) && (ln_w < timing.v_sync_end);
        hs = !vs && (px_w >= timing.h_sync_start) && (px_w < timing.h_sync_end);

        px_wrap = (px_w + 1'b1 >= timing.h_total) || (px == CNT_MAX);
        ln_wrap = (ln_w + 1'b1 >= timing.v_total) || (ln == CNT_MAX);

        res_next = '0;
        if (timing.valid && output_enable) begin
            res_next.line_index   = ln;
            res_next.pixel_index  = px;
            res_next.active_video = !(hb || vb);
            res_next.h_blank      = hb;
            res_next.v_blank      = vb;
            res_next.h_sync       = hs;
            res_next.v_sync       = vs;
        end

        // invalid timing holds the counters, apart from a restart
        pixel_cnt_next = px;
        line_cnt_next  = ln;
        if (timing.valid) begin
            if (px_wrap) begin
                pixel_cnt_next = '0;
                line_cnt_next  = ln_wrap ? '0 : ln + 1'b1;
            end else begin
                pixel_cnt_next = px + 1'b1;
            end
        end

        m_tvalid_next = s_accept || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_cnt_reg <= '0;
            line_cnt_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (s_accept) begin
                pixel_cnt_reg <= pixel_cnt_next;
                line_cnt_reg  <= line_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(vtg_pkg::OUT_TDATA_W - vtg_pkg::OUT_BITS){1'b0}}, res_reg};

`ifndef NO_ASSERTIONS
    // a one-pixel line wraps right away, so the line may already be one
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && restart |=> (pixel_cnt_reg <= 1) && (line_cnt_reg <= 1))
        else $error("counters not cleared by restart");

    a_counters_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(pixel_cnt_reg) && $stable(line_cnt_reg))
        else $error("counters moved without an accepted word");

    a_blank_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(res_reg.h_blank && res_reg.v_blank))
        else $error("h_blank and v_blank both set");

    a_sync_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(res_reg.h_sync && res_reg.v_sync))
        else $error("h_sync and v_sync both set");

    a_active_vs_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && res_reg.active_video |-> !res_reg.h_blank && !res_reg.v_blank)
        else $error("active video during blank");
`endif

endmodule

`default_nettype wire

>>> sv/vtg_cfg_regs.sv
`default_nettype none

module vtg_cfg_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [vtg_pkg::REG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [vtg_pkg::FIELD_BITS-1:0]      cfg_data,
    output vtg_pkg::timing_t                         timing
);

    vtg_pkg::field_t h_visible_reg, h_front_porch_reg, h_sync_len_reg, h_back_porch_reg;
    vtg_pkg::field_t v_visible_reg, v_front_porch_reg, v_sync_len_reg, v_back_porch_reg;
    vtg_pkg::reg_idx_t idx;

    assign idx = vtg_pkg::reg_idx_t'(cfg_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_visible_reg     <= '0;
            h_front_porch_reg <= '0;
            h_sync_len_reg    <= '0;
            h_back_porch_reg  <= '0;
            v_visible_reg     <= '0;
            v_front_porch_reg <= '0;
            v_sync_len_reg    <= '0;
            v_back_porch_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (idx)
                vtg_pkg::REG_H_VISIBLE:     h_visible_reg     <= cfg_data;
                vtg_pkg::REG_H_FRONT_PORCH: h_front_porch_reg <= cfg_data;
                vtg_pkg::REG_H_SYNC_LEN:    h_sync_len_reg    <= cfg_data;
                vtg_pkg::REG_H_BACK_PORCH:  h_back_porch_reg  <= cfg_data;
                vtg_pkg::REG_V_VISIBLE:     v_visible_reg     <= cfg_data;
                vtg_pkg::REG_V_FRONT_PORCH: v_front_porch_reg <= cfg_data;
                vtg_pkg::REG_V_SYNC_LEN:    v_sync_len_reg    <= cfg_data;
                vtg_pkg::REG_V_BACK_PORCH:  v_back_porch_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        timing.valid        = (h_visible_reg != '0) && (v_visible_reg != '0);
        timing.h_visible    = vtg_pkg::cmp_t'(h_visible_reg);
        timing.h_sync_start = vtg_pkg::cmp_t'(h_visible_reg) + vtg_pkg::cmp_t'(h_front_porch_reg);
        timing.h_sync_end   = timing.h_sync_start + vtg_pkg::cmp_t'(h_sync_len_reg);
        timing.h_total      = timing.h_sync_end + vtg_pkg::cmp_t'(h_back_porch_reg);
        timing.v_visible    = vtg_pkg::cmp_t'(v_visible_reg);
        timing.v_sync_start = vtg_pkg::cmp_t'(v_visible_reg) + vtg_pkg::cmp_t'(v_front_porch_reg);
        timing.v_sync_end   = timing.v_sync_start + vtg_pkg::cmp_t'(v_sync_len_reg);
        timing.v_total      = timing.v_sync_end + vtg_pkg::cmp_t'(v_back_porch_reg);
    end

endmodule

`default_nettype wire
